>>> hdl/wildcard_byte_signature_matcher_assert.svh
// Assertion macros for the wildcard byte signature matcher checks
`ifndef WILDCARD_BYTE_SIGNATURE_MATCHER_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_MATCHER_ASSERT_SVH

// Concurrent assertion on a named clock, disabled while the named reset is low
`define WBSM_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on clk, disabled while arst_n is low
`define WBSM_ASSERT(lbl, prop, msg) \
	`WBSM_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

>>> hdl/wbsm_pkg.sv
// Shared constants, register indexes and types of the signature matcher
`timescale 1ns / 1ps

package wbsm_pkg;

	// Sizing
	localparam int MAX_PATTERN = 32;
	localparam int OFFSET_BITS = 32;
	localparam int SIG_BYTES   = 32;
	localparam int LEN_W       = 7;
	localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_LOW  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_MLOW = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_MHI  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES_HIGH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK      = 3'd5;

	localparam logic [5:0] PATTERN_LENGTH_RESET = 6'd1;

	// Programmed signature as seen by the window logic
	typedef struct packed {
		logic [5:0]                pattern_length;
		logic [SIG_BYTES-1:0][7:0] sig;
		logic [SIG_BYTES-1:0]      wildcard_mask;
	} wbsm_cfg_t;

	// Outcome of the item held in the input register
	typedef struct packed {
		logic        hit;
		logic        produce;
		logic [31:0] offset;
	} wbsm_status_t;

endpackage

>>> hdl/wbsm_if.sv
// Handshake channel interfaces: byte stream, result and configuration write
`timescale 1ns / 1ps

interface wbsm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       region_end;

	modport source (output valid, output data_byte, output region_end, input ready);
	modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbsm_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbsm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wbsm_pkg::CFG_INDEX_W-1:0] index;
	logic [wbsm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/wildcard_byte_signature_matcher.sv
// Top level of the wildcard byte signature matcher
// Takes one byte of a region per cycle and reports the first place where the
// programmed signature occurs, wildcard positions matching any byte. The byte
// that causes a result is caught in an input register, and the masked compare
// of the whole 32-byte window feeds the result register. Input is held off
// only while a finished result waits in the result register and the byte in
// hand would make another. Each region yields one result: found with the
// start offset, or not-found when the last byte passes without a match; bytes
// after a match are dropped up to the end of the region. Configuration writes
// are taken in every cycle and are meant for times when no region is in
// flight.
`timescale 1ns / 1ps

module wildcard_byte_signature_matcher (
	input  logic     clk,
	input  logic     arst_n,
	wbsm_in_if.sink  byte_stream,
	wbsm_out_if.source result,
	wbsm_cfg_if.sink cfg_write
);
	import wbsm_pkg::*;

	wbsm_cfg_t    cfg_q;
	wbsm_status_t status;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        out_free;

	logic        out_valid_q;
	logic        found_q;
	logic [31:0] offset_q;

	// Configuration registers
	assign cfg_write.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_length <= PATTERN_LENGTH_RESET;
			cfg_q.sig            <= '0;
			cfg_q.wildcard_mask  <= '0;
		end else if (cfg_write.valid) begin
			case (cfg_write.index)
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_write.data[5:0];
				end
				REG_PATTERN_BYTES_LOW: begin
					cfg_q.sig[7:0] <= cfg_write.data;
				end
				REG_PATTERN_BYTES_MLOW: begin
					cfg_q.sig[15:8] <= cfg_write.data;
				end
				REG_PATTERN_BYTES_MHI: begin
					cfg_q.sig[23:16] <= cfg_write.data;
				end
				REG_PATTERN_BYTES_HIGH: begin
					cfg_q.sig[31:24] <= cfg_write.data;
				end
				REG_WILDCARD_MASK: begin
					cfg_q.wildcard_mask <= cfg_write.data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake: the held item moves on unless its result has nowhere to go
	assign out_free          = !out_valid_q || result.ready;
	assign advance           = valid_s1 && (!status.produce || out_free);
	assign byte_stream.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.data_byte;
			last_s1 <= byte_stream.region_end;
		end
	end

	wbsm_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step       (advance),
		.data_byte  (byte_s1),
		.region_end (last_s1),
		.status     (status)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && status.produce) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && status.produce) begin
			found_q  <= status.hit;
			offset_q <= status.offset;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.match_offset = offset_q;

endmodule

>>> hdl/wbsm_window.sv
// Shift window, byte counter and masked parallel signature compare
`timescale 1ns / 1ps

module wbsm_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wbsm_pkg::wbsm_cfg_t   cfg,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  region_end,
	output wbsm_pkg::wbsm_status_t status
);
	import wbsm_pkg::*;

	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [OFFSET_BITS-1:0]      count_q;
	logic                        reported_q;

	logic [MAX_PATTERN-1:0][7:0] win_next;
	logic [OFFSET_BITS-1:0]      count_next;
	logic [LEN_W-1:0]            eff_len;
	logic                        all_ok;

	// Clamp the programmed length into 1..MAX_PATTERN
	always_comb begin
		eff_len = {1'b0, cfg.pattern_length};
		if (eff_len == '0) begin
			eff_len = LEN_W'(1);
		end
		if (eff_len > LEN_W'(MAX_PATTERN)) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end
	end

	// Window with the new byte shifted in at the newest end
	always_comb begin
		win_next[0] = data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_next[k] = win_q[k-1];
		end
	end

	// Saturating byte count
	assign count_next = (count_q == '1) ? count_q : count_q + 1'b1;

	// Signature byte i lines up with window position len-1-i
	always_comb begin
		logic [LEN_W-1:0] idx;
		logic [7:0]       want;
		logic             wild;
		all_ok = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			idx  = eff_len - LEN_W'(i) - LEN_W'(1);
			want = (i < SIG_BYTES) ? cfg.sig[i % SIG_BYTES] : 8'h00;
			wild = (i < SIG_BYTES) ? cfg.wildcard_mask[i % SIG_BYTES] : 1'b0;
			if ((LEN_W'(i) < eff_len) && !wild && (win_next[idx[PTR_W-1:0]] != want)) begin
				all_ok = 1'b0;
			end
		end
	end

	// Outcome: a hit, or a not-found at the end of an unmatched region
	always_comb begin
		status.hit     = !reported_q && all_ok && (count_next >= OFFSET_BITS'(eff_len));
		status.produce = !reported_q && (status.hit || region_end);
		status.offset  = status.hit ? 32'(count_next - OFFSET_BITS'(eff_len)) : 32'd0;
	end

	// Advance the region state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (step) begin
			if (region_end) begin
				win_q      <= '0;
				count_q    <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				win_q   <= win_next;
				count_q <= count_next;
				if (status.hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/wbsm_checker.sv
// Port-level checks of the signature matcher and their bind
`timescale 1ns / 1ps
`include "wildcard_byte_signature_matcher_assert.svh"

module wbsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [31:0] match_offset,
	input logic        cfg_ready
);

	// Hold a stalled result
	`WBSM_ASSERT(a_out_valid_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`WBSM_ASSERT(a_out_data_hold, out_valid && !out_ready |=> $stable(found) && $stable(match_offset), "result changed while stalled")

	// A not-found item carries a zero offset
	`WBSM_ASSERT(a_notfound_zero, out_valid && !found |-> match_offset == 32'd0, "not-found with nonzero offset")

	// With the result register empty, the input side never stalls
	`WBSM_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")

	// Configuration writes are always taken
	`WBSM_ASSERT(a_cfg_ready, 1'b1 |-> cfg_ready, "configuration port not ready")

endmodule

bind wildcard_byte_signature_matcher wbsm_checker u_wbsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (byte_stream.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.found        (result.found),
	.match_offset (result.match_offset),
	.cfg_ready    (cfg_write.ready)
);
